/* src/sdeh_pkg.sv */
// shared constants and codes for the homing sequencer
package sdeh_pkg;

  localparam int POS_WIDTH   = 24;
  localparam int COUNT_WIDTH = 16;
  localparam int RATE_WIDTH  = 16;
  localparam int TIME_WIDTH  = 32;

  localparam int OVS_WIDTH   = 12;
  localparam int LIMIT_WIDTH = 10;
  localparam int GRACE_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_ADDR_WIDTH = 2;

  localparam int IN_BITS  = 1 + POS_WIDTH + 2 * RATE_WIDTH + TIME_WIDTH;
  localparam int IN_TDATA_WIDTH  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + 2 + (POS_WIDTH - 1);
  localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_OVERSHOOT = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_STALL_LIM = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_GRACE     = 2'd2;

  localparam logic [OVS_WIDTH-1:0]   OVS_RESET   = 12'd100;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd20;
  localparam logic [GRACE_WIDTH-1:0] GRACE_RESET = 16'd20;

  // request kinds
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // homing phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_FWD      = 3'd1;
  localparam logic [2:0] PH_SETTLE_F = 3'd2;
  localparam logic [2:0] PH_REV      = 3'd3;
  localparam logic [2:0] PH_SETTLE_R = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;
  localparam logic [2:0] PH_FAIL     = 3'd6;

  // drive and status codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  // duty thresholds as multipliers of the sample count (duty scale 2^DUTY_SHIFT)
  localparam int DUTY_SHIFT = 8;
  localparam logic [DUTY_SHIFT-1:0] MUL_HIGH_ARM = 8'd128; // k < 128
  localparam logic [DUTY_SHIFT-1:0] MUL_HIGH_REV = 8'd201; // k > 200
  localparam logic [DUTY_SHIFT-1:0] MUL_LOW_REV  = 8'd100; // k < 100

  localparam logic [1:0] CMP_ARM  = 2'd0;
  localparam logic [1:0] CMP_HIGH = 2'd1;
  localparam logic [1:0] CMP_LOW  = 2'd2;

endpackage

/* src/switch_duty_edge_homing.sv */
// homing sequencer top level with shared duty compare unit
//
// usage: the host writes the three config registers (overshoot, stall rate limit,
// grace ticks) through cfg_we/cfg_addr/cfg_wdata while the block is idle. each
// slave word carries one request: tuser 0 starts the homing run, tuser 1 is a
// periodic sample (switch level, summed position, both motor rates, time).
// every accepted word produces exactly one master word with the drive command,
// the status and the position correction.
// steps: a word goes from acceptance to a result in the output register through
// one step that updates the switch counters, three passes through the shared
// multiply-compare unit (one per duty threshold) and one step that updates the phase.
// s_tready is high only while the sequencer waits for a word, so one word is
// handled at a time: a new word is taken only after the previous one is through.
// the output register holds the result until m_tready; the next word can be
// taken meanwhile, but its update waits while the previous result is unread.
// reset (rst, synchronous) returns the sequencer to idle, clears all homing
// state and loads the config registers with their default values.
module switch_duty_edge_homing import sdeh_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]    cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0]    cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // switch_on, position_sum, rate_first, rate_second, time_now, zero fill
  input  logic [IN_TDATA_WIDTH-1:0]    s_tdata,
  // req_type
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // drive_cmd, status, pos_correction, zero fill
  output logic [OUT_TDATA_WIDTH-1:0]   m_tdata
);

  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_COUNT = 3'd1;
  localparam logic [2:0] SQ_CMP   = 3'd2;
  localparam logic [2:0] SQ_UPD   = 3'd3;

  localparam int ABS_WIDTH = RATE_WIDTH + 1;
  localparam int PROD_WIDTH = COUNT_WIDTH + DUTY_SHIFT;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

  // config registers
  logic [OVS_WIDTH-1:0]   overshoot;
  logic [LIMIT_WIDTH-1:0] stall_limit;
  logic [GRACE_WIDTH-1:0] grace;

  // latched request
  logic                          in_req;
  logic                          in_sw;
  logic signed [POS_WIDTH-1:0]   in_pos;
  logic signed [RATE_WIDTH-1:0]  in_r1;
  logic signed [RATE_WIDTH-1:0]  in_r2;
  logic [TIME_WIDTH-1:0]         in_time;

  // homing state
  logic [2:0]                    seq;
  logic [1:0]                    cmp_sel;
  logic [2:0]                    phase, phase_next;
  logic [COUNT_WIDTH-1:0]        on_count, on_count_next;
  logic [COUNT_WIDTH-1:0]        sample_count, sample_count_next;
  logic signed [POS_WIDTH-1:0]   checkpoint, checkpoint_next;
  logic signed [POS_WIDTH-1:0]   stop_position, stop_position_next;
  logic                          stop_armed, stop_armed_next;
  logic                          high_seen, high_seen_next;
  logic [TIME_WIDTH-1:0]         deadline, deadline_next;
  logic                          k_lt_arm, k_gt_rev, k_lt_low;

  logic [1:0]                    drive_v, status_v;
  logic [POS_WIDTH-2:0]          corr_v;

  // shared multiply-compare unit: on_count * 256 < mul * sample_count
  logic [DUTY_SHIFT-1:0]         duty_mul;
  logic [COUNT_WIDTH-1:0]        count_eff;
  logic [PROD_WIDTH-1:0]         duty_lhs, duty_rhs;
  logic                          duty_lt;

  always_comb begin
    case (cmp_sel)
      CMP_ARM:  duty_mul = MUL_HIGH_ARM;
      CMP_HIGH: duty_mul = MUL_HIGH_REV;
      default:  duty_mul = MUL_LOW_REV;
    endcase
    count_eff = (sample_count == '0) ? COUNT_WIDTH'(1) : sample_count;
    duty_lhs  = {on_count, {DUTY_SHIFT{1'b0}}};
    duty_rhs  = PROD_WIDTH'(count_eff) * PROD_WIDTH'(duty_mul);
    duty_lt   = duty_lhs < duty_rhs;
  end

  // rate and time conditions
  logic [ABS_WIDTH-1:0]  abs1, abs2, lim_ext;
  logic                  stalled, settled, past;
  logic [TIME_WIDTH-1:0] time_diff;

  always_comb begin
    abs1 = in_r1[RATE_WIDTH-1] ? (ABS_WIDTH'(0) - {in_r1[RATE_WIDTH-1], in_r1})
                               : {1'b0, in_r1};
    abs2 = in_r2[RATE_WIDTH-1] ? (ABS_WIDTH'(0) - {in_r2[RATE_WIDTH-1], in_r2})
                               : {1'b0, in_r2};
    lim_ext   = {{(ABS_WIDTH-LIMIT_WIDTH){1'b0}}, stall_limit};
    stalled   = (abs1 < lim_ext) || (abs2 < lim_ext);
    settled   = (abs1 <= lim_ext) && (abs2 <= lim_ext);
    time_diff = in_time - deadline;
    past      = (time_diff != '0) && !time_diff[TIME_WIDTH-1];
  end

  // phase update
  logic signed [POS_WIDTH:0] stop_sum;
  logic                      fwd_end;
  logic                      rev_end;
  logic [TIME_WIDTH-1:0]     new_deadline;

  always_comb begin
    phase_next         = phase;
    on_count_next      = on_count;
    sample_count_next  = sample_count;
    checkpoint_next    = checkpoint;
    stop_position_next = stop_position;
    stop_armed_next    = stop_armed;
    high_seen_next     = high_seen;
    deadline_next      = deadline;
    drive_v            = DRV_STOP;
    status_v           = ST_BUSY;
    corr_v             = '0;
    fwd_end            = 1'b0;
    rev_end            = 1'b0;
    new_deadline       = in_time + {{(TIME_WIDTH-GRACE_WIDTH){1'b0}}, grace};
    stop_sum           = {checkpoint[POS_WIDTH-1], checkpoint}
                         + {{(POS_WIDTH+1-OVS_WIDTH){1'b0}}, overshoot};

    if (in_req == REQ_START) begin
      phase_next         = PH_FWD;
      deadline_next      = new_deadline;
      on_count_next      = '0;
      sample_count_next  = '0;
      checkpoint_next    = '0;
      stop_position_next = '0;
      stop_armed_next    = 1'b0;
      high_seen_next     = 1'b0;
      drive_v            = DRV_FWD;
    end else begin
      case (phase)
        PH_FWD: begin
          drive_v = DRV_FWD;
          if (in_pos > checkpoint) begin
            on_count_next     = '0;
            sample_count_next = '0;
            if (k_lt_arm) begin
              stop_armed_next    = 1'b0;
              stop_position_next = '0;
            end else if (!stop_armed) begin
              // overshoot can only overflow upward
              stop_position_next = (stop_sum[POS_WIDTH] != stop_sum[POS_WIDTH-1])
                                   ? POS_MAX : stop_sum[POS_WIDTH-1:0];
              stop_armed_next    = 1'b1;
            end
            checkpoint_next = in_pos;
            if (stop_armed_next && (in_pos >= stop_position_next))
              fwd_end = 1'b1;
          end
          if (stalled && past)
            fwd_end = 1'b1;
          if (fwd_end) begin
            phase_next = PH_SETTLE_F;
            drive_v    = DRV_STOP;
          end
        end
        PH_SETTLE_F: begin
          if (settled) begin
            phase_next        = PH_REV;
            on_count_next     = '0;
            sample_count_next = '0;
            high_seen_next    = 1'b0;
            checkpoint_next   = in_pos;
            deadline_next     = new_deadline;
            drive_v           = DRV_REV;
          end
        end
        PH_REV: begin
          drive_v = DRV_REV;
          if (in_pos < checkpoint) begin
            on_count_next     = '0;
            sample_count_next = '0;
            if (k_gt_rev)
              high_seen_next = 1'b1;
            if (k_lt_low && high_seen_next)
              rev_end = 1'b1;
            else
              checkpoint_next = in_pos;
          end
          if (rev_end) begin
            phase_next = PH_SETTLE_R;
            drive_v    = DRV_STOP;
          end else if (stalled && past) begin
            phase_next = PH_FAIL;
            drive_v    = DRV_STOP;
            status_v   = ST_FAIL;
          end
        end
        PH_SETTLE_R: begin
          if (settled) begin
            phase_next = PH_DONE;
            status_v   = ST_DONE;
            corr_v     = checkpoint[POS_WIDTH-1:1];
          end
        end
        PH_DONE: begin
          status_v = ST_DONE;
          corr_v   = checkpoint[POS_WIDTH-1:1];
        end
        PH_FAIL: begin
          status_v = ST_FAIL;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  logic out_free;
  logic out_load;
  logic counting;

  assign s_tready = (seq == SQ_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (seq == SQ_UPD) && out_free;
  assign counting = (in_req == REQ_SAMPLE) && ((phase == PH_FWD) || (phase == PH_REV));

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      overshoot   <= OVS_RESET;
      stall_limit <= LIMIT_RESET;
      grace       <= GRACE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OVERSHOOT: overshoot   <= cfg_wdata[OVS_WIDTH-1:0];
        REG_STALL_LIM: stall_limit <= cfg_wdata[LIMIT_WIDTH-1:0];
        REG_GRACE:     grace       <= cfg_wdata[GRACE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input latch, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_sw   <= s_tdata[0];
      in_pos  <= s_tdata[POS_WIDTH:1];
      in_r1   <= s_tdata[POS_WIDTH+RATE_WIDTH:POS_WIDTH+1];
      in_r2   <= s_tdata[POS_WIDTH+2*RATE_WIDTH:POS_WIDTH+RATE_WIDTH+1];
      in_time <= s_tdata[IN_BITS-1:POS_WIDTH+2*RATE_WIDTH+1];
    end
  end

  // sequencer and homing state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= SQ_IDLE;
      cmp_sel       <= CMP_ARM;
      phase         <= PH_IDLE;
      on_count      <= '0;
      sample_count  <= '0;
      checkpoint    <= '0;
      stop_position <= '0;
      stop_armed    <= 1'b0;
      high_seen     <= 1'b0;
      deadline      <= '0;
      k_lt_arm      <= 1'b0;
      k_gt_rev      <= 1'b0;
      k_lt_low      <= 1'b0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      if (out_load)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      case (seq)
        SQ_IDLE: begin
          if (s_tvalid)
            seq <= SQ_COUNT;
        end
        SQ_COUNT: begin
          if (counting) begin
            if (sample_count != CNT_MAX)
              sample_count <= sample_count + COUNT_WIDTH'(1);
            if (in_sw && (on_count != CNT_MAX))
              on_count <= on_count + COUNT_WIDTH'(1);
          end
          cmp_sel <= CMP_ARM;
          seq     <= SQ_CMP;
        end
        SQ_CMP: begin
          case (cmp_sel)
            CMP_ARM:  k_lt_arm <= duty_lt;
            CMP_HIGH: k_gt_rev <= !duty_lt;
            default:  k_lt_low <= duty_lt;
          endcase
          if (cmp_sel == CMP_LOW)
            seq <= SQ_UPD;
          else
            cmp_sel <= cmp_sel + 2'd1;
        end
        SQ_UPD: begin
          // wait here while the previous word is still unread
          if (out_free) begin
            phase         <= phase_next;
            on_count      <= on_count_next;
            sample_count  <= sample_count_next;
            checkpoint    <= checkpoint_next;
            stop_position <= stop_position_next;
            stop_armed    <= stop_armed_next;
            high_seen     <= high_seen_next;
            deadline      <= deadline_next;
            m_tdata       <= OUT_TDATA_WIDTH'({corr_v, status_v, drive_v});
            seq           <= SQ_IDLE;
          end
        end
        default: begin
          seq <= SQ_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/homing_result_check.sv */
`timescale 1ns / 100ps
// result checker for the homing sequencer: tracks the channels, predicts each result and compares
module homing_result_check import sdeh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  input  logic                       s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  output int                         fail_count,
  output int                         pending_words,
  output logic [2:0]                 phase_now
);

  localparam int SW_BIT    = 0;
  localparam int POS_LSB   = 1;
  localparam int RATE1_LSB = POS_LSB + POS_WIDTH;
  localparam int RATE2_LSB = RATE1_LSB + RATE_WIDTH;
  localparam int TIME_LSB  = RATE2_LSB + RATE_WIDTH;

  localparam int DUTY_ARM  = 128;
  localparam int DUTY_HIGH = 200;
  localparam int DUTY_LOW  = 100;

  localparam logic signed [POS_WIDTH+1:0] POS_TOP =
      (POS_WIDTH+2)'((1 <<< (POS_WIDTH - 1)) - 1);

  typedef struct packed {
    logic [1:0]           drive;
    logic [1:0]           status;
    logic [POS_WIDTH-2:0] corr;
  } homing_result_t;

  logic [OVS_WIDTH-1:0]          overshoot;
  logic [LIMIT_WIDTH-1:0]        rate_limit;
  logic [GRACE_WIDTH-1:0]        grace;

  logic [2:0]                    phase;
  logic [COUNT_WIDTH-1:0]        on_cnt;
  logic [COUNT_WIDTH-1:0]        sample_cnt;
  logic signed [POS_WIDTH-1:0]   checkpoint;
  logic signed [POS_WIDTH-1:0]   stop_pos;
  logic                          stop_armed;
  logic                          high_seen;
  logic [TIME_WIDTH-1:0]         deadline;

  homing_result_t due_results[$];
  homing_result_t want_res;
  homing_result_t got_res;

  function automatic logic [RATE_WIDTH:0] rate_mag(input logic [RATE_WIDTH-1:0] raw);
    logic signed [RATE_WIDTH:0] wide;
    wide = $signed({raw[RATE_WIDTH-1], raw});
    return wide[RATE_WIDTH] ? -wide : wide;
  endfunction

  // wrap-safe: strictly after the deadline and less than half the counter range away
  function automatic logic overdue(input logic [TIME_WIDTH-1:0] now);
    logic [TIME_WIDTH-1:0] gap;
    gap = now - deadline;
    return (gap != '0) && !gap[TIME_WIDTH-1];
  endfunction

  function automatic void tally_sample(input logic sw);
    if (sample_cnt != '1) sample_cnt++;
    if (sw && on_cnt != '1) on_cnt++;
  endfunction

  function automatic int take_duty();
    int duty;
    duty = (int'(on_cnt) << DUTY_SHIFT) / ((sample_cnt == '0) ? 1 : int'(sample_cnt));
    on_cnt = '0;
    sample_cnt = '0;
    return duty;
  endfunction

  task automatic predict_homing(input logic kind, input logic [IN_TDATA_WIDTH-1:0] word);
    logic                        sw;
    logic signed [POS_WIDTH-1:0] pos;
    logic [RATE_WIDTH:0]         mag1;
    logic [RATE_WIDTH:0]         mag2;
    logic [TIME_WIDTH-1:0]       now;
    logic                        stalled;
    logic                        settled;
    logic                        finish;
    logic signed [POS_WIDTH+1:0] reach;
    int                          duty;
    homing_result_t              res;
    sw = word[SW_BIT];
    pos = word[POS_LSB +: POS_WIDTH];
    mag1 = rate_mag(word[RATE1_LSB +: RATE_WIDTH]);
    mag2 = rate_mag(word[RATE2_LSB +: RATE_WIDTH]);
    now = word[TIME_LSB +: TIME_WIDTH];
    stalled = (mag1 < rate_limit) || (mag2 < rate_limit);
    settled = (mag1 <= rate_limit) && (mag2 <= rate_limit);
    finish = 1'b0;
    res.drive = DRV_STOP;
    res.status = ST_BUSY;
    res.corr = '0;
    if (kind == REQ_START) begin
      phase = PH_FWD;
      deadline = now + grace;
      on_cnt = '0;
      sample_cnt = '0;
      checkpoint = '0;
      stop_pos = '0;
      stop_armed = 1'b0;
      high_seen = 1'b0;
      res.drive = DRV_FWD;
    end else begin
      case (phase)
        PH_FWD: begin
          res.drive = DRV_FWD;
          tally_sample(sw);
          if (pos > checkpoint) begin
            duty = take_duty();
            if (duty < DUTY_ARM) begin
              stop_armed = 1'b0;
              stop_pos = '0;
            end else if (!stop_armed) begin
              // stop point saturates at the top of the position range
              reach = checkpoint + $signed({1'b0, overshoot});
              stop_pos = (reach > POS_TOP) ? POS_TOP[POS_WIDTH-1:0] : reach[POS_WIDTH-1:0];
              stop_armed = 1'b1;
            end
            checkpoint = pos;
            if (stop_armed && pos >= stop_pos) finish = 1'b1;
          end
          if (!finish && stalled && overdue(now)) finish = 1'b1;
          if (finish) begin
            phase = PH_SETTLE_F;
            res.drive = DRV_STOP;
          end
        end
        PH_SETTLE_F: begin
          // the settling word only seeds the reverse trace
          if (settled) begin
            phase = PH_REV;
            on_cnt = '0;
            sample_cnt = '0;
            high_seen = 1'b0;
            checkpoint = pos;
            deadline = now + grace;
            res.drive = DRV_REV;
          end
        end
        PH_REV: begin
          res.drive = DRV_REV;
          tally_sample(sw);
          if (pos < checkpoint) begin
            duty = take_duty();
            if (duty > DUTY_HIGH) high_seen = 1'b1;
            if (duty < DUTY_LOW && high_seen) finish = 1'b1;
            else checkpoint = pos;
          end
          if (finish) begin
            phase = PH_SETTLE_R;
            res.drive = DRV_STOP;
          end else if (stalled && overdue(now)) begin
            phase = PH_FAIL;
            res.drive = DRV_STOP;
            res.status = ST_FAIL;
          end
        end
        PH_SETTLE_R: begin
          if (settled) begin
            phase = PH_DONE;
            res.status = ST_DONE;
            res.corr = checkpoint[POS_WIDTH-1:1];
          end
        end
        PH_DONE: begin
          res.status = ST_DONE;
          res.corr = checkpoint[POS_WIDTH-1:1];
        end
        PH_FAIL: res.status = ST_FAIL;
        default: phase = PH_IDLE;
      endcase
    end
    due_results.push_back(res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      overshoot = OVS_RESET;
      rate_limit = LIMIT_RESET;
      grace = GRACE_RESET;
      phase = PH_IDLE;
      on_cnt = '0;
      sample_cnt = '0;
      checkpoint = '0;
      stop_pos = '0;
      stop_armed = 1'b0;
      high_seen = 1'b0;
      deadline = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      // the word leaving now belongs to an earlier request, so compare before predicting
      if (m_tvalid && m_tready) begin
        got_res.drive = m_tdata[1:0];
        got_res.status = m_tdata[3:2];
        got_res.corr = m_tdata[4 +: POS_WIDTH - 1];
        if (due_results.size() == 0) begin
          $display("%0t ns: result word %h with nothing pending", $time, m_tdata);
          fail_count++;
        end else begin
          want_res = due_results.pop_front();
          check_field("drive_cmd", want_res.drive, got_res.drive);
          check_field("status", want_res.status, got_res.status);
          check_field("pos_correction", $signed(want_res.corr), $signed(got_res.corr));
        end
      end
      if (s_tvalid && s_tready) predict_homing(s_tuser, s_tdata);
      if (cfg_we) begin
        case (cfg_addr)
          REG_OVERSHOOT: overshoot = cfg_wdata[OVS_WIDTH-1:0];
          REG_STALL_LIM: rate_limit = cfg_wdata[LIMIT_WIDTH-1:0];
          REG_GRACE:     grace = cfg_wdata[GRACE_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    pending_words = due_results.size();
    phase_now = phase;
  end

endmodule

/* tb/switch_duty_edge_homing_tb.sv */
`timescale 1ns / 100ps
// testbench top for the homing sequencer: stimulus, stream handshakes and verdict
module switch_duty_edge_homing_tb;
  import sdeh_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int SETUPS       = 7;
  localparam int SET_QUOTA    = 150;
  localparam int RUN_GUARD    = 600;
  localparam int TIMEOUT_NS   = 20_000_000;
  localparam int POS_HI  = (1 << (POS_WIDTH - 1)) - 1;
  localparam int POS_LO  = -(1 << (POS_WIDTH - 1));
  localparam int RATE_HI = (1 << (RATE_WIDTH - 1)) - 1;
  localparam int RATE_LO = -(1 << (RATE_WIDTH - 1));

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;

  int         fail_count;
  int         pending_words;
  logic [2:0] model_phase;

  int       words_sent = 0;
  int       burst_left = 0;
  int       ovs_now = int'(OVS_RESET);
  int       lim_now = int'(LIMIT_RESET);
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  switch_duty_edge_homing uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  homing_result_check watch (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .phase_now     (model_phase)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: stretches of always ready, coin flips, sparse and mostly ready
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
      default:   m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[switch_duty_edge_homing] ERROR");
    $finish;
  end

  function automatic logic [IN_TDATA_WIDTH-1:0] sample_word(input logic sw, input int pos,
      input int r1, input int r2, input logic [TIME_WIDTH-1:0] tick);
    logic [IN_TDATA_WIDTH-1:0] w;
    w = '0;
    w[IN_BITS-1:0] = {tick, RATE_WIDTH'(r2), RATE_WIDTH'(r1), POS_WIDTH'(pos), sw};
    return w;
  endfunction

  function automatic int signed_rate(input int mag);
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  function automatic int moving_rate();
    return $urandom_range(lim_now + 1, ($urandom_range(0, 3) == 0) ? RATE_HI : lim_now + 1500);
  endfunction

  function automatic int still_rate();
    return (lim_now == 0) ? 0 : $urandom_range(0, lim_now - 1);
  endfunction

  function automatic int clamp_pos(input int pos);
    return (pos > POS_HI) ? POS_HI : (pos < POS_LO) ? POS_LO : pos;
  endfunction

  task automatic go_quiet();
    s_tvalid = 1'b0;
    burst_left = 0;
  endtask

  // sender in bursts; valid stays up across a burst and the next word replaces the data
  task automatic send_word(input logic kind, input logic [IN_TDATA_WIDTH-1:0] word);
    int gap;
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    words_sent++;
    if (burst_left == 0) s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx, input int value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = CFG_DATA_WIDTH'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one homing run over a virtual axis with a home switch zone, steered by the predicted phase
  task automatic homing_run(input int quota);
    int                    pos;
    int                    home;
    int                    span;
    int                    step;
    int                    guard;
    int                    tail;
    int                    r1;
    int                    r2;
    logic                  sw;
    logic                  live;
    logic [TIME_WIDTH-1:0] tick;
    step = 3 + ovs_now / 32;
    span = 6 * step + $urandom_range(4, 80);
    case ($urandom_range(0, 9))
      0: begin
        pos = POS_HI - int'($urandom_range(50, 400 + ovs_now));
        home = pos + int'($urandom_range(5, 40));
      end
      1: begin
        pos = 0 - int'($urandom_range(1, 300));
        home = int'($urandom_range(0, 250)) - 50;
      end
      default: begin
        pos = $urandom_range(0, 300);
        home = pos + int'($urandom_range(4 * step, 500));
      end
    endcase
    tick = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    send_word(REQ_START, sample_word(1'($urandom_range(0, 1)), pos, signed_rate(moving_rate()),
        signed_rate(moving_rate()), tick));
    live = 1'b1;
    guard = 0;
    tail = $urandom_range(1, 3);
    while (live && guard < RUN_GUARD && words_sent < quota) begin
      guard++;
      tick += $urandom_range(1, 12);
      if ($urandom_range(0, 29) == 0) tick += $urandom_range(0, 70000);
      r1 = signed_rate(moving_rate());
      r2 = signed_rate(moving_rate());
      case (model_phase)
        PH_FWD: begin
          pos = clamp_pos(pos + int'($urandom_range(0, step)));
          if ($urandom_range(0, 49) == 0) r1 = signed_rate(still_rate());
        end
        PH_REV: begin
          pos = clamp_pos(pos - int'($urandom_range(0, step)));
          if ($urandom_range(0, 89) == 0) r2 = signed_rate(still_rate());
        end
        PH_SETTLE_F, PH_SETTLE_R: begin
          if ($urandom_range(0, 3) != 0) begin
            r1 = signed_rate($urandom_range(0, lim_now));
            r2 = signed_rate($urandom_range(0, lim_now));
          end
        end
        PH_DONE, PH_FAIL: begin
          tail--;
          live = (tail > 0);
        end
        default: live = 1'b0;
      endcase
      sw = ((pos >= home) && (pos < home + span)) ^ ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 49) == 0)
        send_word(REQ_SAMPLE, sample_word(1'($urandom_range(0, 1)), int'($urandom),
            int'($urandom), int'($urandom), $urandom));
      else if ($urandom_range(0, 199) == 0)
        send_word(REQ_START, sample_word(sw, pos, r1, r2, tick));
      else
        send_word(REQ_SAMPLE, sample_word(sw, pos, r1, r2, tick));
    end
  endtask

  initial begin
    int   quota;
    int   mid;
    int   ovs;
    int   lim;
    int   grace;
    logic paused;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed walk with the reset settings: overshoot 100, limit 20, grace 20
    send_word(REQ_SAMPLE, sample_word(1'b1, POS_HI, RATE_LO, RATE_HI, 32'hFFFF_FFFF));
    send_word(REQ_SAMPLE, sample_word(1'b0, POS_LO, 0, 0, 32'h0));
    // deadline wraps past zero
    send_word(REQ_START, sample_word(1'b0, 0, 0, 0, 32'hFFFF_FFF0));
    send_word(REQ_SAMPLE, sample_word(1'b1, 5, 0, 500, 32'hFFFF_FFF8));
    // stalled exactly at the deadline is not yet overdue
    send_word(REQ_SAMPLE, sample_word(1'b1, 5, 7, 600, 32'h4));
    send_word(REQ_SAMPLE, sample_word(1'b1, 6, RATE_HI, RATE_LO, 32'h5));
    // forward stall ends the forward run
    send_word(REQ_SAMPLE, sample_word(1'b0, 6, 19, -900, 32'h6));
    send_word(REQ_SAMPLE, sample_word(1'b0, 6, 21, 0, 32'h7));
    send_word(REQ_SAMPLE, sample_word(1'b0, 50, 20, -20, 32'hA));
    send_word(REQ_SAMPLE, sample_word(1'b1, 49, 400, -400, 32'hB));
    send_word(REQ_SAMPLE, sample_word(1'b0, 48, 400, 400, 32'hC));
    send_word(REQ_SAMPLE, sample_word(1'b1, 48, 3, -4, 32'hD));
    send_word(REQ_SAMPLE, sample_word(1'b0, 0, 0, 0, 32'hE));
    // restart from done, then reverse stall gives a failure
    send_word(REQ_START, sample_word(1'b1, 0, 900, 900, 32'd100));
    send_word(REQ_SAMPLE, sample_word(1'b0, -5, 5, 5, 32'd200));
    send_word(REQ_SAMPLE, sample_word(1'b0, -7, 0, 0, 32'd201));
    send_word(REQ_SAMPLE, sample_word(1'b0, -9, 2, 300, 32'd1300));
    send_word(REQ_SAMPLE, sample_word(1'b1, -9, 300, 300, 32'd1301));
    send_word(REQ_START, sample_word(1'b0, 0, 0, 0, 32'd2000));
    send_word(REQ_START, sample_word(1'b1, 0, 0, 0, 32'd2001));
    // top of the position range, largest correction
    send_word(REQ_SAMPLE, sample_word(1'b1, POS_HI, 500, 500, 32'd2002));
    send_word(REQ_SAMPLE, sample_word(1'b0, POS_HI, 0, 0, 32'd2003));
    send_word(REQ_SAMPLE, sample_word(1'b1, POS_HI - 1, 900, 900, 32'd2004));
    send_word(REQ_SAMPLE, sample_word(1'b0, POS_HI - 2, 900, 900, 32'd2005));
    send_word(REQ_SAMPLE, sample_word(1'b0, 0, 1, 1, 32'd2006));

    for (int set_idx = 0; set_idx < SETUPS; set_idx++) begin
      if (set_idx > 0) begin
        case (set_idx)
          1: begin ovs = 0; lim = 0; grace = 0; end
          2: begin ovs = 4095; lim = 1023; grace = 65535; end
          3: begin ovs = 37; lim = 300; grace = 5; end
          4: begin
            ovs = $urandom_range(0, 600);
            lim = $urandom_range(1, 200);
            grace = $urandom_range(0, 300);
          end
          5: begin
            ovs = $urandom_range(0, 4095);
            lim = $urandom_range(0, 1023);
            grace = $urandom_range(0, 65535);
          end
          default: begin
            ovs = $urandom_range(0, 60);
            lim = $urandom_range(0, 40);
            grace = $urandom_range(0, 40);
          end
        endcase
        go_quiet();
        wait_drained();
        write_reg(REG_OVERSHOOT, ovs);
        write_reg(REG_STALL_LIM, lim);
        write_reg(REG_GRACE, grace);
        ovs_now = ovs;
        lim_now = lim;
      end
      quota = words_sent + SET_QUOTA;
      mid = words_sent + SET_QUOTA / 2;
      paused = 1'b0;
      while (words_sent < quota) begin
        // hold off until the pipe is empty once per setting
        if (!paused && words_sent >= mid) begin
          go_quiet();
          wait_drained();
          paused = 1'b1;
        end
        homing_run(quota);
      end
    end

    go_quiet();
    wait_drained();
    if (fail_count == 0)
      $display("[switch_duty_edge_homing] OK");
    else
      $display("[switch_duty_edge_homing] ERROR");
    $finish;
  end

endmodule
